// ----- hdl/tccw_pkg.sv -----
`default_nettype none

package tccw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int INDEX_W = 11;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int CELL_W  = CHAR_W + COLOR_W;

   localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd7;

   localparam logic [CHAR_W-1:0] SPACE_CHAR     = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
   localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;

   localparam logic KIND_PRINT = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef logic [CELL_W-1:0] cell_type;

   function automatic cell_type make_cell(input logic [CHAR_W-1:0] chr,
                                          input logic [COLOR_W-1:0] attr);
      return {attr, chr};
   endfunction

endpackage

`default_nettype wire

// ----- hdl/tccw_screen_ram.sv -----
`default_nettype none

module tccw_screen_ram #(
   parameter int DEPTH = tccw_pkg::COLUMNS_DEF * tccw_pkg::ROWS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                       clock,
   input  wire                       we,
   input  wire  [AW-1:0]             waddr,
   input  wire  tccw_pkg::cell_type  wdata,
   input  wire                       re,
   input  wire  [AW-1:0]             raddr,
   output tccw_pkg::cell_type        rdata
);

   tccw_pkg::cell_type mem [DEPTH];
   tccw_pkg::cell_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- hdl/text_console_char_writer.sv -----
`default_nettype none

// Text console engine with a screen of ROWS x COLUMNS cells held in one
// synchronous RAM, each cell a character byte and an attribute byte.
// An item is taken when start is high and busy is low. A print item writes
// its character at the cursor (newline and backspace move the cursor), and a
// read item fetches one cell. Every item yields one result, shown for exactly
// one cycle with rsp_valid high. Without a scroll the result comes in the
// cycle after it is taken; busy stays low, so new items may follow each cycle.
// A print item that finds the cursor past the last cell first scrolls the
// screen. The scroll copies the rows up by one through the RAM's read port and
// its write port, one cell per cycle, and fills the last row with spaces in the
// default color. Busy stays high through the scroll, drain and pend states; the
// result follows the pend state. After reset the RAM is cleared to spaces in
// attribute 7, one cell per cycle, so busy stays high until every cell is
// cleared. The default color register is written through the csr_ channel,
// which is always ready. The receiver cannot stall: results are never held back.
module text_console_char_writer #(
   parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire                                 req_kind,
   input  wire  [tccw_pkg::CHAR_W-1:0]         req_ch,
   input  wire  [tccw_pkg::COLOR_W-1:0]        req_color,
   input  wire                                 req_use_default_color,
   input  wire  [tccw_pkg::INDEX_W-1:0]        req_read_index,
   output logic                                rsp_valid,
   output logic [tccw_pkg::INDEX_W-1:0]        rsp_cursor_cell,
   output logic [tccw_pkg::CHAR_W-1:0]         rsp_cell_char,
   output logic [tccw_pkg::COLOR_W-1:0]        rsp_cell_color,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [tccw_pkg::COLOR_W-1:0]        csr_data
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(CELLS + 1);
   localparam int COLW  = $clog2(COLUMNS);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCROLL = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_PEND   = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [AW-1:0]                 sw_ff, sw_in;
   logic [CW-1:0]                 cursor_ff, cursor_in;
   logic [COLW-1:0]               col_ff, col_in;
   logic [tccw_pkg::COLOR_W-1:0]  default_color_ff;
   logic [tccw_pkg::CHAR_W-1:0]   pend_ch_ff, pend_ch_in;
   logic [tccw_pkg::COLOR_W-1:0]  pend_attr_ff, pend_attr_in;

   logic                          wr_pend_ff, wr_pend_in;
   logic                          wr_copy_ff, wr_copy_in;
   logic [AW-1:0]                 wr_idx_ff, wr_idx_in;
   tccw_pkg::cell_type            wr_cell_ff, wr_cell_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_rd_ff, rsp_rd_in;
   logic [CW-1:0]                 rsp_cursor_ff, rsp_cursor_in;

   logic                          accept, do_print, do_read, read_ok, start_scroll;
   logic                          at_end, sweep_last;
   logic [tccw_pkg::CHAR_W-1:0]   item_ch;
   logic [tccw_pkg::COLOR_W-1:0]  req_attr, item_attr;
   logic                          pw_we;
   logic [AW-1:0]                 pw_addr;
   tccw_pkg::cell_type            pw_data;
   logic [CW-1:0]                 pr_cursor;
   logic [COLW-1:0]               pr_col;

   logic                          mem_we, mem_re;
   logic [AW-1:0]                 mem_waddr, mem_raddr;
   tccw_pkg::cell_type            mem_wdata, mem_rdata;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign at_end    = (cursor_ff == CW'(CELLS));
   assign read_ok   = (32'(req_read_index) < 32'(CELLS));
   assign do_read   = accept && (req_kind == tccw_pkg::KIND_READ);
   assign start_scroll = accept && (req_kind == tccw_pkg::KIND_PRINT) && at_end;
   assign do_print  = (accept && (req_kind == tccw_pkg::KIND_PRINT) && !at_end)
                      || (state_ff == ST_PEND);
   assign sweep_last = (sw_ff == AW'(CELLS - 1));
   assign req_attr  = req_use_default_color ? default_color_ff : req_color;
   assign item_ch   = (state_ff == ST_PEND) ? pend_ch_ff : req_ch;
   assign item_attr = (state_ff == ST_PEND) ? pend_attr_ff : req_attr;

   always_comb begin
      pw_we     = 1'b0;
      pw_addr   = cursor_ff[AW-1:0];
      pw_data   = tccw_pkg::make_cell(item_ch, item_attr);
      pr_cursor = cursor_ff;
      pr_col    = col_ff;
      if (item_ch == tccw_pkg::NEWLINE_CHAR) begin
         pr_cursor = cursor_ff + CW'(COLUMNS) - CW'(col_ff);
         pr_col    = '0;
      end else if (item_ch == tccw_pkg::BACKSPACE_CHAR) begin
         if (cursor_ff != '0) begin
            pr_cursor = cursor_ff - CW'(1);
            pr_col    = (col_ff == '0) ? COLW'(COLUMNS - 1) : col_ff - COLW'(1);
            pw_we     = do_print;
            pw_addr   = pr_cursor[AW-1:0];
            pw_data   = tccw_pkg::make_cell(tccw_pkg::SPACE_CHAR, item_attr);
         end
      end else begin
         pr_cursor = cursor_ff + CW'(1);
         pr_col    = (col_ff == COLW'(COLUMNS - 1)) ? '0 : col_ff + COLW'(1);
         pw_we     = do_print;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sw_in        = sw_ff;
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      pend_ch_in   = pend_ch_ff;
      pend_attr_in = pend_attr_ff;
      wr_pend_in   = 1'b0;
      wr_copy_in   = 1'b0;
      wr_idx_in    = sw_ff;
      wr_cell_in   = tccw_pkg::make_cell(tccw_pkg::SPACE_CHAR, default_color_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            sw_in = sweep_last ? '0 : sw_ff + AW'(1);
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start_scroll) begin
               state_in     = ST_SCROLL;
               sw_in        = '0;
               pend_ch_in   = req_ch;
               pend_attr_in = req_attr;
            end
         end
         ST_SCROLL: begin
            wr_pend_in = 1'b1;
            wr_copy_in = (sw_ff < AW'(CELLS - COLUMNS));
            sw_in      = sweep_last ? '0 : sw_ff + AW'(1);
            if (sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in  = ST_PEND;
            cursor_in = CW'(CELLS - COLUMNS);
            col_in    = '0;
         end
         ST_PEND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (do_print) begin
         cursor_in = pr_cursor;
         col_in    = pr_col;
      end
   end

   assign rsp_valid_in  = do_print || do_read;
   assign rsp_rd_in     = do_read && read_ok;
   assign rsp_cursor_in = do_print ? pr_cursor : cursor_ff;

   always_comb begin
      mem_we    = pw_we;
      mem_waddr = pw_addr;
      mem_wdata = pw_data;
      if (wr_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wr_idx_ff;
         mem_wdata = wr_copy_ff ? mem_rdata : wr_cell_ff;
      end else if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = sw_ff;
         mem_wdata = tccw_pkg::make_cell(tccw_pkg::SPACE_CHAR, tccw_pkg::RESET_COLOR);
      end
   end

   assign mem_re    = (do_read && read_ok) || wr_copy_in;
   assign mem_raddr = do_read ? AW'(req_read_index) : sw_ff + AW'(COLUMNS);

   tccw_screen_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         sw_ff            <= '0;
         cursor_ff        <= '0;
         col_ff           <= '0;
         default_color_ff <= tccw_pkg::RESET_COLOR;
         wr_pend_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         rsp_rd_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_rd_ff    <= rsp_rd_in;
         if (csr_valid && csr_ready) begin
            default_color_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ch_ff    <= pend_ch_in;
      pend_attr_ff  <= pend_attr_in;
      wr_copy_ff    <= wr_copy_in;
      wr_idx_ff     <= wr_idx_in;
      wr_cell_ff    <= wr_cell_in;
      rsp_cursor_ff <= rsp_cursor_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor_cell = tccw_pkg::INDEX_W'(rsp_cursor_ff);
   assign rsp_cell_char   = rsp_rd_ff ? mem_rdata[tccw_pkg::CHAR_W-1:0] : '0;
   assign rsp_cell_color  = rsp_rd_ff ? mem_rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W] : '0;

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CW'(CELLS))
      else $error("cursor beyond the end of the screen");

   a_col_at_end: assert property (@(posedge clock) disable iff (reset)
      at_end |-> (col_ff == '0))
      else $error("column not zero with cursor past the end");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> !pw_we)
      else $error("print write collides with scroll copy");

   a_pend_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PEND) |-> ($past(state_ff) == ST_DRAIN))
      else $error("pending print without a finished scroll");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(accept) || $past(state_ff) == ST_PEND))
      else $error("result without an item");

endmodule

`default_nettype wire

// ----- bench/tb_text_console_char_writer.sv -----
`timescale 1ns / 1ps

module tb_text_console_char_writer;

   localparam int COLUMNS = tccw_pkg::COLUMNS_DEF;
   localparam int ROWS    = tccw_pkg::ROWS_DEF;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int CHAR_W  = tccw_pkg::CHAR_W;
   localparam int COLOR_W = tccw_pkg::COLOR_W;
   localparam int INDEX_W = tccw_pkg::INDEX_W;
   localparam int CELL_W  = tccw_pkg::CELL_W;

   typedef struct {
      logic               kind;
      logic [CHAR_W-1:0]  ch;
      logic [COLOR_W-1:0] color;
      logic               use_default_color;
      logic [INDEX_W-1:0] read_index;
   } console_item_type;

   typedef struct {
      logic [INDEX_W-1:0] cursor_cell;
      logic [CHAR_W-1:0]  cell_char;
      logic [COLOR_W-1:0] cell_color;
   } console_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_kind = tccw_pkg::KIND_PRINT;
   logic [CHAR_W-1:0]  req_ch = '0;
   logic [COLOR_W-1:0] req_color = '0;
   logic               req_use_default_color = 1'b0;
   logic [INDEX_W-1:0] req_read_index = '0;
   logic               rsp_valid;
   logic [INDEX_W-1:0] rsp_cursor_cell;
   logic [CHAR_W-1:0]  rsp_cell_char;
   logic [COLOR_W-1:0] rsp_cell_color;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COLOR_W-1:0] csr_data = '0;

   console_item_type   pending_items [$];
   console_result_type expected_results [$];

   tccw_pkg::cell_type screen_model [CELLS];
   int                 cursor_model;
   logic [COLOR_W-1:0] color_model;

   logic item_taken = 1'b0;
   int   items_sent = 0;
   int   mismatch_count = 0;

   text_console_char_writer u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_kind              (req_kind),
      .req_ch                (req_ch),
      .req_color             (req_color),
      .req_use_default_color (req_use_default_color),
      .req_read_index        (req_read_index),
      .rsp_valid             (rsp_valid),
      .rsp_cursor_cell       (rsp_cursor_cell),
      .rsp_cell_char         (rsp_cell_char),
      .rsp_cell_color        (rsp_cell_color),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data)
   );

   always #10 clock = ~clock;

   function automatic console_result_type predict_console(input console_item_type item);
      console_result_type res;
      logic [COLOR_W-1:0] attr;
      int                 i;
      res.cursor_cell = '0;
      res.cell_char   = '0;
      res.cell_color  = '0;
      attr = item.use_default_color ? color_model : item.color;
      if (item.kind == tccw_pkg::KIND_READ) begin
         if (item.read_index < CELLS) begin
            res.cell_char  = screen_model[item.read_index][CHAR_W-1:0];
            res.cell_color = screen_model[item.read_index][CELL_W-1:CHAR_W];
         end
      end else begin
         if (cursor_model >= CELLS) begin
            for (i = 0; i < CELLS - COLUMNS; i++) begin
               screen_model[i] = screen_model[i + COLUMNS];
            end
            for (i = CELLS - COLUMNS; i < CELLS; i++) begin
               screen_model[i] = {color_model, tccw_pkg::SPACE_CHAR};
            end
            cursor_model = CELLS - COLUMNS;
         end
         if (item.ch == tccw_pkg::NEWLINE_CHAR) begin
            cursor_model = (cursor_model / COLUMNS + 1) * COLUMNS;
         end else if (item.ch == tccw_pkg::BACKSPACE_CHAR) begin
            if (cursor_model >= 1) begin
               cursor_model = cursor_model - 1;
               screen_model[cursor_model] = {attr, tccw_pkg::SPACE_CHAR};
            end
         end else begin
            screen_model[cursor_model] = {attr, item.ch};
            cursor_model = cursor_model + 1;
         end
      end
      res.cursor_cell = cursor_model[INDEX_W-1:0];
      return res;
   endfunction

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Results and configuration writes are checked and predicted at the rising edge.
   always @(posedge clock) begin
      console_item_type   item;
      console_result_type want;
      if (reset) begin
         item_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual cursor %0d",
                        $time, rsp_cursor_cell);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("cursor_cell", want.cursor_cell, rsp_cursor_cell);
               compare_field("cell_char", want.cell_char, rsp_cell_char);
               compare_field("cell_color", want.cell_color, rsp_cell_color);
            end
         end
         if (csr_valid && csr_ready) begin
            color_model = csr_data;
         end
         if (start && !busy) begin
            item.kind              = req_kind;
            item.ch                = req_ch;
            item.color             = req_color;
            item.use_default_color = req_use_default_color;
            item.read_index        = req_read_index;
            expected_results.push_back(predict_console(item));
         end
         item_taken <= start && !busy;
      end
   end

   // Sender holds an item until taken; idles at random except for items 700 to 999.
   always @(negedge clock) begin
      console_item_type item;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !item_taken) begin
         start <= 1'b1;
      end else if (pending_items.size() != 0 &&
                   (($urandom_range(0, 99) >= 22) || (items_sent >= 700 && items_sent < 1000))) begin
         item = pending_items.pop_front();
         req_kind              <= item.kind;
         req_ch                <= item.ch;
         req_color             <= item.color;
         req_use_default_color <= item.use_default_color;
         req_read_index        <= item.read_index;
         start                 <= 1'b1;
         items_sent++;
      end else begin
         start <= 1'b0;
      end
   end

   task automatic queue_item(input logic kind, input logic [CHAR_W-1:0] ch,
                             input logic [COLOR_W-1:0] color, input logic use_def,
                             input logic [INDEX_W-1:0] index);
      console_item_type item;
      item.kind              = kind;
      item.ch                = ch;
      item.color             = color;
      item.use_default_color = use_def;
      item.read_index        = index;
      pending_items.push_back(item);
   endtask

   task automatic queue_random_item();
      int pick;
      logic [CHAR_W-1:0] ch;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         ch = tccw_pkg::NEWLINE_CHAR;
      end else if (pick < 16) begin
         ch = tccw_pkg::BACKSPACE_CHAR;
      end else begin
         ch = CHAR_W'($urandom_range(0, 255));
      end
      queue_item((pick >= 85) ? tccw_pkg::KIND_READ : tccw_pkg::KIND_PRINT, ch,
                 COLOR_W'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                 INDEX_W'($urandom_range(0, 2047)));
   endtask

   task automatic wait_for_drain();
      while (pending_items.size() != 0 || start || expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_default_color(input logic [COLOR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [COLOR_W-1:0] phase_colors [4];
      for (int i = 0; i < CELLS; i++) begin
         screen_model[i] = {tccw_pkg::RESET_COLOR, tccw_pkg::SPACE_CHAR};
      end
      cursor_model = 0;
      color_model  = tccw_pkg::RESET_COLOR;
      phase_colors[0] = 8'h00;
      phase_colors[1] = 8'hFF;
      phase_colors[2] = COLOR_W'($urandom_range(0, 255));
      phase_colors[3] = COLOR_W'($urandom_range(0, 255));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_item(tccw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 11'd0);
      queue_item(tccw_pkg::KIND_READ, 8'hFF, 8'hFF, 1'b1, 11'd1999);
      queue_item(tccw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 11'd2000);
      queue_item(tccw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 11'd2047);
      queue_item(tccw_pkg::KIND_PRINT, tccw_pkg::BACKSPACE_CHAR, 8'h5A, 1'b0, 11'd0);
      queue_item(tccw_pkg::KIND_PRINT, 8'h00, 8'h00, 1'b0, 11'd0);
      queue_item(tccw_pkg::KIND_PRINT, 8'hFF, 8'hFF, 1'b0, 11'd0);
      queue_item(tccw_pkg::KIND_PRINT, 8'h41, 8'hC3, 1'b1, 11'd0);
      queue_item(tccw_pkg::KIND_PRINT, tccw_pkg::BACKSPACE_CHAR, 8'h1E, 1'b0, 11'd0);
      queue_item(tccw_pkg::KIND_PRINT, tccw_pkg::BACKSPACE_CHAR, 8'hE1, 1'b1, 11'd0);
      queue_item(tccw_pkg::KIND_PRINT, tccw_pkg::NEWLINE_CHAR, 8'h00, 1'b0, 11'd0);
      queue_item(tccw_pkg::KIND_PRINT, 8'h7E, 8'h81, 1'b0, 11'd0);
      queue_item(tccw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 11'd0);
      queue_item(tccw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 11'd1);
      queue_item(tccw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 11'd2);
      queue_item(tccw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 11'd79);
      queue_item(tccw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 11'd80);
      wait_for_drain();

      for (int p = 0; p < 4; p++) begin
         write_default_color(phase_colors[p]);
         for (int n = 0; n < 500; n++) begin
            queue_random_item();
         end
         wait_for_drain();
      end

      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
